// ===== hdl/skibs_pkg.sv =====
package skibs_pkg;

    // Table geometry and field widths
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int FUNC_W      = 2;
    localparam int KEY_W       = 31;
    localparam int VAL_W       = 32;
    localparam int STAT_W      = 2;
    localparam int ENTRY_W     = KEY_W + VAL_W;

    // Item operations
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
    localparam logic [STAT_W-1:0] ST_DUP  = 2'd3;

    // Datapath operations, one per microcode step
    typedef enum logic [3:0] {
        OP_ACCEPT   = 4'd0,
        OP_DISPATCH = 4'd1,
        OP_PROBE    = 4'd2,
        OP_NARROW   = 4'd3,
        OP_HIT      = 4'd4,
        OP_SH_INIT  = 4'd5,
        OP_SHIFT    = 4'd6,
        OP_PUT      = 4'd7,
        OP_RESULT   = 4'd8
    } t_op;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEVER       = 4'd0,
        C_ALWAYS      = 4'd1,
        C_NO_ITEM     = 4'd2,
        C_FUNC_SKIP   = 4'd3,
        C_SEARCH_DONE = 4'd4,
        C_NOT_INSERT  = 4'd5,
        C_INS_BLOCKED = 4'd6,
        C_SHIFT_MORE  = 4'd7,
        C_OUT_BUSY    = 4'd8
    } t_cond;

    // Program counter and step addresses
    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc STEP_DISPATCH = 4'd0;
    localparam t_pc STEP_PROBE    = 4'd1;
    localparam t_pc STEP_NARROW   = 4'd2;
    localparam t_pc STEP_HIT      = 4'd3;
    localparam t_pc STEP_INS_CHK  = 4'd4;
    localparam t_pc STEP_SHIFT    = 4'd5;
    localparam t_pc STEP_PUT      = 4'd6;
    localparam t_pc STEP_RESULT   = 4'd7;
    localparam t_pc STEP_WAIT     = 4'd8;
    localparam t_pc STEP_LAST     = STEP_WAIT;

    // One control word
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // Status flags from the datapath to the sequencer
    typedef struct packed {
        logic no_item;
        logic func_skip;
        logic search_done;
        logic not_insert;
        logic ins_blocked;
        logic shift_more;
        logic out_busy;
    } t_flags;

endpackage

// ===== hdl/skibs_if.sv =====
// Request channel: one table operation per item
interface skibs_req_if;
    logic                          valid;
    logic                          ready;
    logic [skibs_pkg::FUNC_W-1:0]  func;
    logic [skibs_pkg::KEY_W-1:0]   key;
    logic [skibs_pkg::VAL_W-1:0]   value;

    modport source (output valid, func, key, value, input ready);
    modport sink   (input valid, func, key, value, output ready);
endinterface

// Response channel: one result per item
interface skibs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [skibs_pkg::STAT_W-1:0]  status;
    logic [skibs_pkg::VAL_W-1:0]   found_value;
    logic [skibs_pkg::CNT_W-1:0]   entry_count;

    modport source (output valid, status, found_value, entry_count, input ready);
    modport sink   (input valid, status, found_value, entry_count, output ready);
endinterface

// ===== hdl/sorted_key_index_binary_search_top.sv =====
// Sorted key/value table, binary-search lookup, microcoded control.
// An insert shifts each entry above its slot one place up, one entry shifted a cycle,
// then writes the new pair; a duplicate or full-table insert writes nothing.
// Clear and unused ops skip the search and go straight to the result.
// One item at a time, the next taken the cycle after its result is registered; a held
// result stalls the input. Reset (sync, active low) empties the table, RAM not cleared.
module sorted_key_index_binary_search_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    skibs_req_if.sink      i_req,
    skibs_rsp_if.source    o_rsp
);

    localparam int AW = skibs_pkg::ADDR_W;
    localparam int CW = skibs_pkg::CNT_W;

    skibs_pkg::t_op    w_op;
    skibs_pkg::t_flags w_flags;

    // Item registers
    logic [skibs_pkg::FUNC_W-1:0] r_func;
    logic [skibs_pkg::KEY_W-1:0]  r_key;
    logic [skibs_pkg::VAL_W-1:0]  r_value;

    // Search and shift state
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_lo;
    logic [CW-1:0] r_hi;
    logic [CW-1:0] r_mid;
    logic [CW-1:0] n_mid;
    logic [CW-1:0] r_ptr;
    logic          r_pend;
    logic [AW-1:0] r_waddr;
    logic          r_hit;
    logic          r_full;
    logic [skibs_pkg::VAL_W-1:0] r_found;

    // Output register
    logic                         r_out_valid;
    logic [skibs_pkg::STAT_W-1:0] r_out_status;
    logic [skibs_pkg::VAL_W-1:0]  r_out_found;
    logic [CW-1:0]                r_out_count;
    logic [skibs_pkg::STAT_W-1:0] n_status;
    logic [skibs_pkg::VAL_W-1:0]  n_found;
    logic                         w_out_free;

    // RAM port signals
    logic                          w_we;
    logic [AW-1:0]                 w_waddr;
    logic [skibs_pkg::ENTRY_W-1:0] w_wdata;
    logic [AW-1:0]                 w_raddr;
    logic [skibs_pkg::ENTRY_W-1:0] w_rdata;
    logic [skibs_pkg::KEY_W-1:0]   w_rd_key;
    logic [skibs_pkg::VAL_W-1:0]   w_rd_val;

    logic w_search_open;
    logic w_shift_go;

    skibs_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_op    (w_op)
    );

    skibs_ram #(
        .WIDTH (skibs_pkg::ENTRY_W),
        .DEPTH (skibs_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_key = w_rdata[skibs_pkg::ENTRY_W-1 -: skibs_pkg::KEY_W];
    assign w_rd_val = w_rdata[skibs_pkg::VAL_W-1:0];

    assign w_search_open = (r_lo < r_hi);
    assign n_mid         = r_lo + ((r_hi - r_lo) >> 1);
    assign w_shift_go    = (r_ptr > r_lo);
    assign w_out_free    = !r_out_valid || o_rsp.ready;

    // Flags for the sequencer
    assign w_flags.no_item     = !i_req.valid;
    assign w_flags.func_skip   = (r_func != skibs_pkg::FUNC_INSERT)
                              && (r_func != skibs_pkg::FUNC_LOOKUP);
    assign w_flags.search_done = !w_search_open;
    assign w_flags.not_insert  = (r_func != skibs_pkg::FUNC_INSERT);
    assign w_flags.ins_blocked = r_hit || r_full;
    assign w_flags.shift_more  = w_shift_go;
    assign w_flags.out_busy    = !w_out_free;

    assign i_req.ready = i_rst_n && (w_op == skibs_pkg::OP_ACCEPT);

    // RAM read address: probe point during search, entry below the pointer when shifting
    always_comb begin
        case (w_op)
            skibs_pkg::OP_PROBE: w_raddr = w_search_open ? n_mid[AW-1:0] : r_lo[AW-1:0];
            skibs_pkg::OP_SHIFT: w_raddr = AW'(r_ptr - CW'(1));
            default:             w_raddr = r_lo[AW-1:0];
        endcase
    end

    // RAM write: shifted entry one place up, or the new pair at its slot
    always_comb begin
        case (w_op)
            skibs_pkg::OP_SHIFT: begin
                w_we    = r_pend;
                w_waddr = r_waddr;
                w_wdata = w_rdata;
            end
            skibs_pkg::OP_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_lo[AW-1:0];
                w_wdata = {r_key, r_value};
            end
            default: begin
                w_we    = 1'b0;
                w_waddr = r_lo[AW-1:0];
                w_wdata = {r_key, r_value};
            end
        endcase
    end

    // Result fields
    always_comb begin
        n_status = skibs_pkg::ST_OK;
        n_found  = '0;
        case (r_func)
            skibs_pkg::FUNC_INSERT: begin
                if (r_hit) begin
                    n_status = skibs_pkg::ST_DUP;
                end else if (r_full) begin
                    n_status = skibs_pkg::ST_FULL;
                end
            end
            skibs_pkg::FUNC_LOOKUP: begin
                if (r_hit) begin
                    n_found = r_found;
                end else begin
                    n_status = skibs_pkg::ST_MISS;
                end
            end
            default: n_status = skibs_pkg::ST_OK;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            if (w_op == skibs_pkg::OP_DISPATCH && r_func == skibs_pkg::FUNC_CLEAR) begin
                r_count <= '0;
            end else if (w_op == skibs_pkg::OP_PUT) begin
                r_count <= r_count + CW'(1);
            end

            if (w_op == skibs_pkg::OP_SH_INIT) begin
                r_pend <= 1'b0;
            end else if (w_op == skibs_pkg::OP_SHIFT) begin
                r_pend <= w_shift_go;
            end

            if (w_op == skibs_pkg::OP_RESULT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (w_op)
            skibs_pkg::OP_ACCEPT: begin
                if (i_req.valid) begin
                    r_func  <= i_req.func;
                    r_key   <= i_req.key;
                    r_value <= i_req.value;
                    r_lo    <= '0;
                    r_hi    <= r_count;
                end
            end
            skibs_pkg::OP_PROBE: begin
                r_mid <= n_mid;
            end
            skibs_pkg::OP_NARROW: begin
                if (w_rd_key < r_key) begin
                    r_lo <= r_mid + CW'(1);
                end else begin
                    r_hi <= r_mid;
                end
            end
            skibs_pkg::OP_HIT: begin
                r_hit   <= (r_lo < r_count) && (w_rd_key == r_key);
                r_found <= w_rd_val;
                r_full  <= (r_count == CW'(skibs_pkg::TABLE_DEPTH));
            end
            skibs_pkg::OP_SH_INIT: begin
                r_ptr <= r_count;
            end
            skibs_pkg::OP_SHIFT: begin
                if (w_shift_go) begin
                    r_ptr <= r_ptr - CW'(1);
                end
                r_waddr <= r_ptr[AW-1:0];
            end
            skibs_pkg::OP_RESULT: begin
                if (w_out_free) begin
                    r_out_status <= n_status;
                    r_out_found  <= n_found;
                    r_out_count  <= r_count;
                end
            end
            default: begin
                r_mid <= r_mid;
            end
        endcase
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.found_value = r_out_found;
    assign o_rsp.entry_count = r_out_count;

endmodule

// ===== hdl/skibs_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port
module skibs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/skibs_seq.sv =====
// Microcode sequencer: control ROM, step counter, conditional jumps
module skibs_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  skibs_pkg::t_flags i_flags,
    output skibs_pkg::t_op    o_op
);

    skibs_pkg::t_pc    r_pc;
    skibs_pkg::t_pc    n_pc;
    skibs_pkg::t_uword w_word;
    logic              w_take;

    // Control program
    function automatic skibs_pkg::t_uword rom(input skibs_pkg::t_pc pc);
        skibs_pkg::t_uword w;
        w = '{skibs_pkg::OP_ACCEPT, skibs_pkg::C_NO_ITEM, skibs_pkg::STEP_WAIT};
        case (pc)
            skibs_pkg::STEP_DISPATCH: w = '{skibs_pkg::OP_DISPATCH,
                skibs_pkg::C_FUNC_SKIP, skibs_pkg::STEP_RESULT};
            skibs_pkg::STEP_PROBE: w = '{skibs_pkg::OP_PROBE,
                skibs_pkg::C_SEARCH_DONE, skibs_pkg::STEP_HIT};
            skibs_pkg::STEP_NARROW: w = '{skibs_pkg::OP_NARROW,
                skibs_pkg::C_ALWAYS, skibs_pkg::STEP_PROBE};
            skibs_pkg::STEP_HIT: w = '{skibs_pkg::OP_HIT,
                skibs_pkg::C_NOT_INSERT, skibs_pkg::STEP_RESULT};
            skibs_pkg::STEP_INS_CHK: w = '{skibs_pkg::OP_SH_INIT,
                skibs_pkg::C_INS_BLOCKED, skibs_pkg::STEP_RESULT};
            skibs_pkg::STEP_SHIFT: w = '{skibs_pkg::OP_SHIFT,
                skibs_pkg::C_SHIFT_MORE, skibs_pkg::STEP_SHIFT};
            skibs_pkg::STEP_PUT: w = '{skibs_pkg::OP_PUT,
                skibs_pkg::C_NEVER, skibs_pkg::STEP_PUT};
            skibs_pkg::STEP_RESULT: w = '{skibs_pkg::OP_RESULT,
                skibs_pkg::C_OUT_BUSY, skibs_pkg::STEP_RESULT};
            skibs_pkg::STEP_WAIT: w = '{skibs_pkg::OP_ACCEPT,
                skibs_pkg::C_NO_ITEM, skibs_pkg::STEP_WAIT};
            default: w = '{skibs_pkg::OP_ACCEPT,
                skibs_pkg::C_NO_ITEM, skibs_pkg::STEP_WAIT};
        endcase
        return w;
    endfunction

    assign w_word = rom(r_pc);
    assign o_op   = w_word.op;

    // Jump condition
    always_comb begin
        case (w_word.cond)
            skibs_pkg::C_NEVER:       w_take = 1'b0;
            skibs_pkg::C_ALWAYS:      w_take = 1'b1;
            skibs_pkg::C_NO_ITEM:     w_take = i_flags.no_item;
            skibs_pkg::C_FUNC_SKIP:   w_take = i_flags.func_skip;
            skibs_pkg::C_SEARCH_DONE: w_take = i_flags.search_done;
            skibs_pkg::C_NOT_INSERT:  w_take = i_flags.not_insert;
            skibs_pkg::C_INS_BLOCKED: w_take = i_flags.ins_blocked;
            skibs_pkg::C_SHIFT_MORE:  w_take = i_flags.shift_more;
            skibs_pkg::C_OUT_BUSY:    w_take = i_flags.out_busy;
            default:                  w_take = 1'b0;
        endcase
    end

    // Next step: jump target, else next word with wrap after the last one
    always_comb begin
        if (w_take) begin
            n_pc = w_word.target;
        end else if (r_pc == skibs_pkg::STEP_LAST) begin
            n_pc = skibs_pkg::STEP_DISPATCH;
        end else begin
            n_pc = r_pc + skibs_pkg::t_pc'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= skibs_pkg::STEP_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== dv/tb_sorted_key_index_binary_search_top.sv =====
module tb_sorted_key_index_binary_search_top;

    typedef logic [skibs_pkg::FUNC_W-1:0] t_func;
    typedef logic [skibs_pkg::KEY_W-1:0]  t_key;
    typedef logic [skibs_pkg::VAL_W-1:0]  t_val;
    typedef logic [skibs_pkg::CNT_W-1:0]  t_cnt;

    // Selector value with no operation behind it
    localparam t_func FUNC_UNUSED = 2'd3;

    localparam t_key KEY_MAX = {skibs_pkg::KEY_W{1'b1}};
    localparam t_val VAL_MAX = {skibs_pkg::VAL_W{1'b1}};

    // Cycles allowed after the last result before the end or a new phase
    localparam int TAIL_CYCLES  = 64;
    localparam int RANDOM_ITEMS = 548;

    typedef struct packed {
        logic [skibs_pkg::STAT_W-1:0] status;
        t_val                         found_value;
        t_cnt                         entry_count;
    } t_table_result;

    logic i_clk;
    logic i_rst_n;

    skibs_req_if req_ch ();
    skibs_rsp_if rsp_ch ();

    sorted_key_index_binary_search_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow copy of the table, always in ascending key order
    t_key        table_key [skibs_pkg::TABLE_DEPTH];
    t_val        table_val [skibs_pkg::TABLE_DEPTH];
    int unsigned table_count;

    t_table_result pending_results [$];
    int            error_count;

    // Sender burst state and pressure controls
    int burst_left;
    bit steady_send;
    bit hold_off_req;
    bit hold_active;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Give up after a generous fixed time
    initial begin
        #64000000;
        $display("tb_sorted_key_index_binary_search_top: done, errors");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    // First slot whose key is not below k; hit when that slot holds k
    function automatic int unsigned find_slot(input t_key k, output bit hit);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = table_count;
        while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if (table_key[mid] < k)
                lo = mid + 1;
            else
                hi = mid;
        end
        hit = (lo < table_count) && (table_key[lo] == k);
        return lo;
    endfunction

    // Applies one item to the shadow table and returns the result it should give
    function automatic t_table_result apply_table_op(input t_func f, input t_key k,
                                                     input t_val v);
        t_table_result r;
        int unsigned   slot;
        int unsigned   idx;
        bit            hit;
        r = '0;
        r.status = skibs_pkg::ST_OK;
        case (f)
            skibs_pkg::FUNC_CLEAR: begin
                table_count = 0;
            end
            skibs_pkg::FUNC_INSERT: begin
                slot = find_slot(k, hit);
                if (hit) begin
                    r.status = skibs_pkg::ST_DUP;
                end else if (table_count >= skibs_pkg::TABLE_DEPTH) begin
                    r.status = skibs_pkg::ST_FULL;
                end else begin
                    for (idx = table_count; idx > slot; idx--) begin
                        table_key[idx] = table_key[idx-1];
                        table_val[idx] = table_val[idx-1];
                    end
                    table_key[slot] = k;
                    table_val[slot] = v;
                    table_count++;
                end
            end
            skibs_pkg::FUNC_LOOKUP: begin
                slot = find_slot(k, hit);
                if (hit)
                    r.found_value = table_val[slot];
                else
                    r.status = skibs_pkg::ST_MISS;
            end
            default: ;
        endcase
        r.entry_count = t_cnt'(table_count);
        return r;
    endfunction

    // Offer one item, in bursts with random gaps unless held steady
    task automatic send_item(input t_func f, input t_key k, input t_val v);
        int gap;
        gap = 0;
        if (!steady_send) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
            burst_left--;
        end
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func  <= f;
        req_ch.key   <= k;
        req_ch.value <= v;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pending_results.push_back(apply_table_op(f, k, v));
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_key rand_key();
        return t_key'($urandom());
    endfunction

    function automatic t_key held_key();
        return table_key[$urandom_range(0, table_count - 1)];
    endfunction

    // Extremes, every operation and the corner cases on a small table
    task automatic test_directed();
        send_item(skibs_pkg::FUNC_LOOKUP, '0, VAL_MAX);               // miss on empty table
        send_item(skibs_pkg::FUNC_INSERT, '0, '0);
        send_item(skibs_pkg::FUNC_INSERT, KEY_MAX, VAL_MAX);
        send_item(skibs_pkg::FUNC_INSERT, 31'd1000, 32'h1234_5678);   // lands in the middle
        send_item(skibs_pkg::FUNC_LOOKUP, '0, '0);
        send_item(skibs_pkg::FUNC_LOOKUP, KEY_MAX, '0);
        send_item(skibs_pkg::FUNC_LOOKUP, 31'd1000, VAL_MAX);
        send_item(skibs_pkg::FUNC_LOOKUP, 31'd999, '0);
        send_item(skibs_pkg::FUNC_INSERT, 31'd1000, 32'hDEAD_BEEF);   // duplicate, first kept
        send_item(skibs_pkg::FUNC_LOOKUP, 31'd1000, '0);
        send_item(FUNC_UNUSED, KEY_MAX, VAL_MAX);
        send_item(skibs_pkg::FUNC_CLEAR, KEY_MAX, VAL_MAX);
        send_item(skibs_pkg::FUNC_LOOKUP, 31'd1000, '0);
        send_item(FUNC_UNUSED, '0, '0);
        send_item(skibs_pkg::FUNC_INSERT, 31'd5, 32'h0000_0005);
        send_item(skibs_pkg::FUNC_INSERT, 31'd3, 32'h8000_0003);
        send_item(skibs_pkg::FUNC_INSERT, 31'd4, 32'h4000_0004);
        send_item(skibs_pkg::FUNC_LOOKUP, 31'd3, '0);
        send_item(skibs_pkg::FUNC_LOOKUP, 31'd4, '0);
        send_item(skibs_pkg::FUNC_LOOKUP, 31'd5, '0);
        send_item(skibs_pkg::FUNC_LOOKUP, 31'd6, '0);
        send_item(skibs_pkg::FUNC_CLEAR, '0, '0);
        drain_results();
    endtask

    // Mostly inserts and lookups, some against held keys, with clears keeping the table small
    task automatic test_random(input int n_items);
        int    sel;
        t_func f;
        t_key  k;
        t_val  v;
        repeat (n_items) begin
            sel = $urandom_range(0, 99);
            v = $urandom();
            k = rand_key();
            if (sel < 4 || (table_count >= 64 && sel < 20)) begin
                f = skibs_pkg::FUNC_CLEAR;
            end else if (sel < 8) begin
                f = FUNC_UNUSED;
            end else if (sel < 54) begin
                f = skibs_pkg::FUNC_INSERT;
                case ($urandom_range(0, 9))
                    0, 1, 2: if (table_count > 0) k = held_key();
                    3, 4, 5: k = t_key'($urandom_range(0, 255));
                    default: ;
                endcase
            end else begin
                f = skibs_pkg::FUNC_LOOKUP;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: if (table_count > 0) k = held_key();
                    6, 7: k = t_key'($urandom_range(0, 255));
                    default: ;
                endcase
            end
            send_item(f, k, v);
        end
        drain_results();
    endtask

    // Receiver holds off for a long stretch while items keep being offered
    task automatic test_hold_off();
        int i;
        hold_off_req = 1'b1;
        wait (hold_active);
        steady_send = 1'b1;
        for (i = 0; i < 10; i++) begin
            if (i % 2 == 0)
                send_item(skibs_pkg::FUNC_INSERT, t_key'($urandom_range(0, 255)), $urandom());
            else
                send_item(skibs_pkg::FUNC_LOOKUP, t_key'($urandom_range(0, 255)), $urandom());
        end
        steady_send = 1'b0;
        drain_results();
    endtask

    // Result checker against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_table_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected, status %0d count %0d",
                                          rsp_ch.status, rsp_ch.entry_count));
            end else begin
                want = pending_results.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              rsp_ch.status, want.status));
                if (rsp_ch.found_value !== want.found_value)
                    report_mismatch($sformatf("found_value %h, expected %h",
                                              rsp_ch.found_value, want.found_value));
                if (rsp_ch.entry_count !== want.entry_count)
                    report_mismatch($sformatf("entry_count %0d, expected %0d",
                                              rsp_ch.entry_count, want.entry_count));
            end
        end
    end

    // Receiver: changing stall styles, plus a long hold-off on request
    initial begin : result_sink
        int style;
        int style_left;
        int cyc;
        style = 0;
        style_left = 0;
        cyc = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_active = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(300, 450)) @(posedge i_clk);
                hold_active = 1'b0;
            end else begin
                if (style_left == 0) begin
                    style = $urandom_range(0, 2);
                    style_left = $urandom_range(50, 300);
                end
                style_left--;
                cyc++;
                case (style)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: rsp_ch.ready <= ((cyc % 8) < 5);
                endcase
            end
        end
    end

    // Main sequence
    initial begin
        error_count = 0;
        table_count = 0;
        burst_left = 0;
        steady_send = 1'b0;
        hold_off_req = 1'b0;
        hold_active = 1'b0;
        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.func  <= skibs_pkg::FUNC_CLEAR;
        req_ch.key   <= '0;
        req_ch.value <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(RANDOM_ITEMS / 2);
        test_hold_off();
        test_random(RANDOM_ITEMS - RANDOM_ITEMS / 2);

        if (error_count == 0)
            $display("tb_sorted_key_index_binary_search_top: done, clean");
        else
            $display("tb_sorted_key_index_binary_search_top: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/skibs_pkg.sv
hdl/skibs_if.sv
hdl/skibs_ram.sv
hdl/skibs_seq.sv
hdl/sorted_key_index_binary_search_top.sv
dv/tb_sorted_key_index_binary_search_top.sv
